>>> src/frs_pkg.sv
// ----------------------------------------------------------------------------
// frs_pkg
// shared types, codes and defaults of the flash request sequencer
// ----------------------------------------------------------------------------
package frs_pkg;

  localparam int unsigned PAGE_BYTES        = 256;
  localparam int unsigned READ_BUF_BYTES    = 4096;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam int unsigned FLASH_PAGES_W     = 17;
  localparam logic [16:0] FLASH_PAGES_RESET = 17'd16384;

  localparam int unsigned SEQ_ADDR_W = 26;
  localparam int unsigned SEQ_REM_W  = 27;
  localparam int unsigned SEQ_OFF_W  = 25;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_ERASE = 2'd2;
  localparam logic [1:0] CMD_NEXT  = 2'd3;

  localparam logic [2:0] OP_READ      = 3'd0;
  localparam logic [2:0] OP_PROGRAM   = 3'd1;
  localparam logic [2:0] OP_ERASE_4K  = 3'd2;
  localparam logic [2:0] OP_ERASE_16K = 3'd3;
  localparam logic [2:0] OP_ERASE_32K = 3'd4;
  localparam logic [2:0] OP_CHIP      = 3'd5;

  localparam logic [1:0] JOB_EMIT  = 2'd0;
  localparam logic [1:0] JOB_WRITE = 2'd1;
  localparam logic [1:0] JOB_ERASE = 2'd2;
  localparam logic [1:0] JOB_NEXT  = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [23:0] start_addr;
    logic [24:0] req_bytes;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  op_kind;
    logic [23:0] flash_address;
    logic [16:0] length;
    logic [24:0] buffer_offset;
    logic [16:0] fill_words;
    logic        status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]           kind;
    out_item_t            result;
    logic [23:0]          addr;
    logic [SEQ_REM_W-1:0] count;
  } job_t;

endpackage

>>> src/frs_fifo.sv
// ----------------------------------------------------------------------------
// frs_fifo
// small first-in first-out queue with full and empty flags
// ----------------------------------------------------------------------------
module frs_fifo #(
  parameter type         item_t = logic,
  parameter int unsigned Depth  = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> src/frs_front.sv
// ----------------------------------------------------------------------------
// frs_front
// classifies requests; plans reads and chip erases, prepares write and erase
// ----------------------------------------------------------------------------
module frs_front #(
  parameter int unsigned PageBytes = frs_pkg::PAGE_BYTES
) (
  input  frs_pkg::in_item_t item_i,
  input  logic [16:0]       flash_pages_i,
  output frs_pkg::job_t     job_o
);
  import frs_pkg::*;

  localparam int unsigned PageLog2 = $clog2(PageBytes);
  localparam int unsigned FbW      = FLASH_PAGES_W + PageLog2;
  localparam int unsigned CmpW     = ((FbW > 25) ? FbW : 25) + 1;

  logic [CmpW-1:0] fb;
  logic [CmpW-1:0] fwords;
  logic [CmpW-1:0] waddr;
  logic [CmpW-1:0] words;
  logic [CmpW-1:0] got;
  logic [CmpW-1:0] fill;
  logic [25:0]     words_sum;
  logic [1:0]      pad;
  logic            oversized;

  assign fb        = CmpW'(flash_pages_i) << PageLog2;
  assign fwords    = fb >> 2;
  assign pad       = item_i.start_addr[1:0];
  assign waddr     = CmpW'(item_i.start_addr[23:2]);
  assign words_sum = 26'(item_i.req_bytes) + 26'(pad) + 26'd3;
  assign words     = CmpW'(words_sum[25:2]);
  assign oversized = (item_i.req_bytes > 25'(READ_BUF_BYTES));

  always_comb begin
    got  = words;
    fill = '0;
    if (waddr + words > fwords) begin
      got  = (waddr <= fwords) ? fwords - waddr : '0;
      fill = words - got;
    end
  end

  always_comb begin
    job_o        = '0;
    job_o.addr   = item_i.start_addr;
    job_o.count  = SEQ_REM_W'(item_i.req_bytes);
    case (item_i.command)
      CMD_READ: begin
        job_o.kind                 = JOB_EMIT;
        job_o.result.op_kind       = OP_READ;
        job_o.result.flash_address = {2'b00, item_i.start_addr[23:2]};
        job_o.result.buffer_offset = 25'(pad);
        job_o.result.last          = 1'b1;
        if (oversized) begin
          job_o.result.status = 1'b1;
        end else begin
          job_o.result.length     = got[16:0];
          job_o.result.fill_words = fill[16:0];
        end
      end
      CMD_WRITE: begin
        job_o.kind = JOB_WRITE;
      end
      CMD_ERASE: begin
        if (item_i.start_addr == '0 && CmpW'(item_i.req_bytes) >= fb) begin
          job_o.kind           = JOB_EMIT;
          job_o.result.op_kind = OP_CHIP;
          job_o.result.last    = 1'b1;
        end else begin
          job_o.kind  = JOB_ERASE;
          job_o.addr  = {item_i.start_addr[23:12], 12'd0};
          job_o.count = SEQ_REM_W'(item_i.req_bytes)
                      + SEQ_REM_W'(item_i.start_addr[11:0]);
        end
      end
      default: begin
        job_o.kind = JOB_NEXT;
      end
    endcase
  end

endmodule

>>> src/frs_back.sv
// ----------------------------------------------------------------------------
// frs_back
// steps write and erase sequences and emits at most one operation per job
// ----------------------------------------------------------------------------
module frs_back #(
  parameter int unsigned PageBytes = frs_pkg::PAGE_BYTES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  frs_pkg::job_t      job_i,
  input  logic               job_valid_i,
  output logic               job_pop_o,
  input  logic               res_full_i,
  output logic               res_push_o,
  output frs_pkg::out_item_t res_o,
  input  logic [16:0]        flash_pages_i
);
  import frs_pkg::*;

  localparam int unsigned PageLog2 = $clog2(PageBytes);
  localparam int unsigned FbW      = FLASH_PAGES_W + PageLog2;
  localparam int unsigned CmpW     = (FbW > SEQ_ADDR_W) ? FbW : SEQ_ADDR_W;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_ERASE = 2'd2;

  logic [1:0]            mode_q, mode_d;
  logic [SEQ_ADDR_W-1:0] addr_q, addr_d;
  logic [SEQ_REM_W-1:0]  rem_q, rem_d;
  logic [SEQ_OFF_W-1:0]  off_q, off_d;

  logic [SEQ_ADDR_W-1:0] cur_addr;
  logic [SEQ_REM_W-1:0]  cur_rem;
  logic [SEQ_OFF_W-1:0]  cur_off;
  logic                  do_wr, do_er, emit, fire;
  logic [CmpW-1:0]       fb;
  logic [PageLog2:0]     room, n;
  logic [SEQ_ADDR_W-1:0] wr_addr;
  logic [SEQ_REM_W-1:0]  wr_rem;
  logic                  wr_last;
  logic [SEQ_REM_W-1:0]  er_size;
  logic [2:0]            er_kind;
  logic [SEQ_ADDR_W-1:0] er_index;

  assign fb   = CmpW'(flash_pages_i) << PageLog2;
  assign fire = job_valid_i && !res_full_i;

  always_comb begin
    emit     = 1'b0;
    res_o    = '0;
    mode_d   = mode_q;
    addr_d   = addr_q;
    rem_d    = rem_q;
    off_d    = off_q;
    cur_addr = addr_q;
    cur_rem  = rem_q;
    cur_off  = off_q;
    do_wr    = 1'b0;
    do_er    = 1'b0;
    case (job_i.kind)
      JOB_EMIT: begin
        emit   = 1'b1;
        res_o  = job_i.result;
        mode_d = MODE_IDLE;
      end
      JOB_WRITE: begin
        cur_addr = SEQ_ADDR_W'(job_i.addr);
        cur_rem  = job_i.count;
        cur_off  = '0;
        do_wr    = 1'b1;
      end
      JOB_ERASE: begin
        cur_addr = SEQ_ADDR_W'(job_i.addr);
        cur_rem  = job_i.count;
        cur_off  = '0;
        do_er    = 1'b1;
      end
      JOB_NEXT: begin
        do_wr = (mode_q == MODE_WRITE);
        do_er = (mode_q == MODE_ERASE);
      end
      default: ;
    endcase

    // page program step
    room    = (PageLog2 + 1)'(PageBytes) - {1'b0, cur_addr[PageLog2-1:0]};
    n       = (cur_rem < SEQ_REM_W'(room)) ? cur_rem[PageLog2:0] : room;
    wr_addr = cur_addr + SEQ_ADDR_W'(n);
    wr_rem  = cur_rem - SEQ_REM_W'(n);
    wr_last = (wr_rem == '0) || (CmpW'(wr_addr) >= fb);

    // erase step, largest aligned block first
    if (cur_addr[14:0] == '0 && cur_rem >= SEQ_REM_W'(32768)) begin
      er_size  = SEQ_REM_W'(32768);
      er_kind  = OP_ERASE_32K;
      er_index = cur_addr >> 15;
    end else if (cur_addr[13:0] == '0 && cur_rem >= SEQ_REM_W'(16384)) begin
      er_size  = SEQ_REM_W'(16384);
      er_kind  = OP_ERASE_16K;
      er_index = cur_addr >> 14;
    end else begin
      er_size  = SEQ_REM_W'(4096);
      er_kind  = OP_ERASE_4K;
      er_index = cur_addr >> 12;
    end

    if (do_wr) begin
      if (cur_rem == '0 || CmpW'(cur_addr) >= fb) begin
        mode_d = MODE_IDLE;
      end else begin
        emit                = 1'b1;
        res_o.op_kind       = OP_PROGRAM;
        res_o.flash_address = cur_addr[23:0];
        res_o.length        = 17'(n);
        res_o.buffer_offset = cur_off;
        res_o.last          = wr_last;
        addr_d              = wr_addr;
        rem_d               = wr_rem;
        off_d               = cur_off + SEQ_OFF_W'(n);
        mode_d              = wr_last ? MODE_IDLE : MODE_WRITE;
      end
    end

    if (do_er) begin
      if (cur_rem == '0) begin
        mode_d = MODE_IDLE;
      end else begin
        emit                = 1'b1;
        res_o.op_kind       = er_kind;
        res_o.flash_address = er_index[23:0];
        addr_d              = cur_addr + SEQ_ADDR_W'(er_size);
        if (cur_rem <= er_size) begin
          rem_d      = '0;
          res_o.last = 1'b1;
          mode_d     = MODE_IDLE;
        end else begin
          rem_d  = cur_rem - er_size;
          mode_d = MODE_ERASE;
        end
      end
    end
  end

  assign job_pop_o  = fire;
  assign res_push_o = fire && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      addr_q <= '0;
      rem_q  <= '0;
      off_q  <= '0;
    end else if (fire) begin
      mode_q <= mode_d;
      addr_q <= addr_d;
      rem_q  <= rem_d;
      off_q  <= off_d;
    end
  end

endmodule

>>> src/flash_request_sequencer.sv
// ----------------------------------------------------------------------------
// flash_request_sequencer
// plans serial flash operations for read, write and erase requests
// ----------------------------------------------------------------------------
// input queue: push an item while full is low; commands are read, write,
//   erase and next step. a read or a chip erase gives one result at once,
//   a write or erase gives its first operation, each next step one more
//   until a result with last set; a new request drops the one in progress
// result queue: the oldest result sits on out_item_o while empty is low
//   and leaves at an edge with pop high
// config channel: cfg_data_i sets the flash size in pages, taken whenever
//   cfg_valid_i is high; cfg_ready_o is always high
// path: an item is held in the job queue, the back end turns it into a result
//   in the result queue, from which it can leave
// throughput: one item per cycle while the result queue is not full; full
//   rises only when both queues have filled because pop is low
// reset: both queues empty, no sequence running, flash size 16384 pages
// ----------------------------------------------------------------------------
module flash_request_sequencer #(
  parameter int unsigned PageBytes  = frs_pkg::PAGE_BYTES,
  parameter int unsigned QueueDepth = frs_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  frs_pkg::in_item_t  in_item_i,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output frs_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [16:0]        cfg_data_i
);
  import frs_pkg::*;

  logic [16:0] flash_pages_q;
  job_t        job_in, job_out;
  logic        job_empty, job_pop;
  logic        res_full, res_push;
  out_item_t   res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_pages_q <= FLASH_PAGES_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      flash_pages_q <= cfg_data_i;
    end
  end

  frs_front #(
    .PageBytes(PageBytes)
  ) u_front (
    .item_i       (in_item_i),
    .flash_pages_i(flash_pages_q),
    .job_o        (job_in)
  );

  frs_fifo #(
    .item_t(job_t),
    .Depth (QueueDepth)
  ) u_job_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (job_in),
    .full_o (full),
    .pop_i  (job_pop),
    .item_o (job_out),
    .empty_o(job_empty)
  );

  frs_back #(
    .PageBytes(PageBytes)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (job_out),
    .job_valid_i  (!job_empty),
    .job_pop_o    (job_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res),
    .flash_pages_i(flash_pages_q)
  );

  frs_fifo #(
    .item_t(out_item_t),
    .Depth (QueueDepth)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .item_i (res),
    .full_o (res_full),
    .pop_i  (pop),
    .item_o (out_item_o),
    .empty_o(empty)
  );

endmodule

>>> src/frs_checker.sv
// ----------------------------------------------------------------------------
// frs_checker
// port-level checks on the result queue of the flash request sequencer
// ----------------------------------------------------------------------------
module frs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input frs_pkg::out_item_t out_item_o
);
  import frs_pkg::*;

  // reads always end their request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.op_kind == OP_READ) |-> out_item_o.last)
    else $error("read item without last");

  // an oversized read fetches nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.status) |->
      (out_item_o.length == '0 && out_item_o.fill_words == '0))
    else $error("oversized read with nonzero length");

  // erases carry no length, offset or fill
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.op_kind != OP_READ && out_item_o.op_kind != OP_PROGRAM)
      |-> (out_item_o.length == '0 && out_item_o.buffer_offset == '0
           && out_item_o.fill_words == '0 && !out_item_o.status))
    else $error("erase item with payload");

  // a waiting item stays until popped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("item dropped without pop");

endmodule

bind flash_request_sequencer frs_checker u_frs_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .empty     (empty),
  .pop       (pop),
  .out_item_o(out_item_o)
);

>>> tb/frs_plan_checker.sv
// ----------------------------------------------------------------------------
// frs_plan_checker
// watches the sequencer channels, plans each request itself and compares
// every popped result field by field with the oldest planned operation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frs_plan_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               full_i,
  input  frs_pkg::in_item_t  in_item_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  frs_pkg::out_item_t out_item_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [16:0]        cfg_data_i,
  output int unsigned        errors_o,
  output int unsigned        waiting_o,
  output int unsigned        checked_o
);
  import frs_pkg::*;

  typedef enum logic [1:0] {SEQ_IDLE, SEQ_WRITE, SEQ_ERASE} seq_mode_e;

  seq_mode_e   mode      = SEQ_IDLE;
  logic [16:0] pages     = FLASH_PAGES_RESET;
  logic [25:0] next_addr = '0;
  logic [26:0] remaining = '0;
  logic [24:0] data_off  = '0;
  out_item_t   planned_ops[$];
  int unsigned errors    = 0;
  int unsigned checked   = 0;

  function automatic logic [25:0] flash_size();
    return {1'b0, pages, 8'h00};
  endfunction

  function automatic bit program_op(output out_item_t op);
    logic [26:0] room;
    logic [26:0] n;
    op = '0;
    if (remaining == 0 || next_addr >= flash_size()) begin
      mode = SEQ_IDLE;
      return 1'b0;
    end
    room = 27'(PAGE_BYTES) - 27'(next_addr % PAGE_BYTES);
    n = (remaining < room) ? remaining : room;
    op.op_kind       = OP_PROGRAM;
    op.flash_address = next_addr[23:0];
    op.length        = n[16:0];
    op.buffer_offset = data_off;
    remaining = remaining - n;
    data_off  = data_off + n[24:0];
    next_addr = next_addr + n[25:0];
    op.last = (remaining == 0) || (next_addr >= flash_size());
    if (op.last) begin
      mode = SEQ_IDLE;
    end
    return 1'b1;
  endfunction

  // greedy pick of the largest aligned block that the rest still needs
  function automatic bit erase_op(output out_item_t op);
    logic [26:0] span;
    op = '0;
    if (remaining == 0) begin
      mode = SEQ_IDLE;
      return 1'b0;
    end
    if (next_addr[14:0] == 0 && remaining >= 27'd32768) begin
      span = 27'd32768;
      op.op_kind = OP_ERASE_32K;
      op.flash_address = 24'(next_addr >> 15);
    end else if (next_addr[13:0] == 0 && remaining >= 27'd16384) begin
      span = 27'd16384;
      op.op_kind = OP_ERASE_16K;
      op.flash_address = 24'(next_addr >> 14);
    end else begin
      span = 27'd4096;
      op.op_kind = OP_ERASE_4K;
      op.flash_address = 24'(next_addr >> 12);
    end
    next_addr = next_addr + span[25:0];
    if (remaining <= span) begin
      remaining = '0;
      op.last = 1'b1;
      mode = SEQ_IDLE;
    end else begin
      remaining = remaining - span;
    end
    return 1'b1;
  endfunction

  function automatic out_item_t read_op(logic [23:0] addr, logic [24:0] count);
    logic [24:0] words;
    logic [24:0] fwords;
    logic [24:0] waddr;
    logic [24:0] got;
    out_item_t   op;
    op = '0;
    op.op_kind       = OP_READ;
    op.flash_address = {2'b00, addr[23:2]};
    op.buffer_offset = {23'd0, addr[1:0]};
    op.last          = 1'b1;
    if (count > READ_BUF_BYTES) begin
      op.status = 1'b1;
      return op;
    end
    waddr  = {3'b000, addr[23:2]};
    words  = 25'((27'(addr[1:0]) + 27'(count) + 27'd3) >> 2);
    fwords = 25'(flash_size() >> 2);
    got    = words;
    // words past the end of the flash are counted as fill words
    if (waddr + words > fwords) begin
      got = (waddr <= fwords) ? fwords - waddr : '0;
    end
    op.length     = got[16:0];
    op.fill_words = 17'(words - got);
    return op;
  endfunction

  function automatic bit plan_item(in_item_t it, output out_item_t op);
    op = '0;
    if (it.command == CMD_NEXT) begin
      if (mode == SEQ_WRITE) begin
        return program_op(op);
      end else if (mode == SEQ_ERASE) begin
        return erase_op(op);
      end else begin
        return 1'b0;
      end
    end
    // any new request drops the sequence in progress
    mode      = SEQ_IDLE;
    next_addr = '0;
    remaining = '0;
    data_off  = '0;
    if (it.command == CMD_READ) begin
      op = read_op(it.start_addr, it.req_bytes);
      return 1'b1;
    end else if (it.command == CMD_WRITE) begin
      mode      = SEQ_WRITE;
      next_addr = 26'(it.start_addr);
      remaining = 27'(it.req_bytes);
      return program_op(op);
    end else if (it.start_addr == 0 && 26'(it.req_bytes) >= flash_size()) begin
      op.op_kind = OP_CHIP;
      op.last    = 1'b1;
      return 1'b1;
    end else begin
      mode      = SEQ_ERASE;
      remaining = 27'(it.req_bytes) + 27'(it.start_addr[11:0]);
      next_addr = {2'b00, it.start_addr[23:12], 12'd0};
      return erase_op(op);
    end
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s expected %0h actual %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : watch
    out_item_t op;
    out_item_t want;
    if (!rst_ni) begin
      mode      = SEQ_IDLE;
      pages     = FLASH_PAGES_RESET;
      next_addr = '0;
      remaining = '0;
      data_off  = '0;
      planned_ops.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        pages = cfg_data_i;
      end
      if (pop_i && !empty_i) begin
        if (planned_ops.size() == 0) begin
          $error("unexpected result op_kind %0d flash_address %0h",
                 out_item_i.op_kind, out_item_i.flash_address);
          errors++;
        end else begin
          want = planned_ops.pop_front();
          check_field("op_kind", want.op_kind, out_item_i.op_kind);
          check_field("flash_address", want.flash_address, out_item_i.flash_address);
          check_field("length", want.length, out_item_i.length);
          check_field("buffer_offset", want.buffer_offset, out_item_i.buffer_offset);
          check_field("fill_words", want.fill_words, out_item_i.fill_words);
          check_field("status", want.status, out_item_i.status);
          check_field("last", want.last, out_item_i.last);
          checked++;
        end
      end
      if (push_i && !full_i) begin
        if (plan_item(in_item_i, op)) begin
          planned_ops.push_back(op);
        end
      end
    end
    errors_o  <= errors;
    checked_o <= checked;
    waiting_o <= planned_ops.size();
  end

endmodule

>>> tb/tb_flash_request_sequencer.sv
// ----------------------------------------------------------------------------
// tb_flash_request_sequencer
// drives read, write, erase and next-step items with random idling on both
// queues across several flash sizes; a checker beside the block plans every
// request and compares all results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_flash_request_sequencer;
  import frs_pkg::*;

  logic        clk_i;
  logic        rst_ni    = 1'b0;
  logic        push      = 1'b0;
  logic        pop       = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [16:0] cfg_data  = FLASH_PAGES_RESET;
  in_item_t    in_item   = '0;
  logic        full;
  logic        empty;
  logic        cfg_ready;
  out_item_t   out_item;

  int unsigned errors;
  int unsigned waiting;
  int unsigned checked;
  int unsigned items_sent = 0;
  int unsigned sizes_used = 1;
  logic [16:0] pages_now  = FLASH_PAGES_RESET;
  bit          burst      = 1'b0;
  bit          hold_req   = 1'b0;

  flash_request_sequencer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .in_item_i   (in_item),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  frs_plan_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_i      (full),
    .in_item_i   (in_item),
    .empty_i     (empty),
    .pop_i       (pop),
    .out_item_i  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .errors_o    (errors),
    .waiting_o   (waiting),
    .checked_o   (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // push stays high between back-to-back items
  task automatic offer(input logic [1:0] cmd, input logic [23:0] addr,
                       input logic [24:0] count);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= '{cmd, addr, count};
    do @(posedge clk_i); while (full);
    items_sent++;
  endtask

  task automatic drain(input int unsigned settle);
    push <= 1'b0;
    do @(posedge clk_i); while (waiting != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic set_flash_pages(input logic [16:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pages_now = value;
    sizes_used++;
  endtask

  function automatic logic [23:0] pick_address();
    logic [25:0] fb;
    fb = {1'b0, pages_now, 8'h00};
    case ($urandom_range(0, 5))
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 300));
      2: return 24'(fb - 26'($urandom_range(1, 600)));
      3: return 24'(fb + 26'($urandom_range(0, 300)));
      4: return 24'($urandom_range(0, 4095) << 12);
      default: return 24'd0;
    endcase
  endfunction

  function automatic logic [24:0] pick_count();
    logic [25:0] fb;
    fb = {1'b0, pages_now, 8'h00};
    case ($urandom_range(0, 5))
      0: return 25'($urandom);
      1: return 25'($urandom_range(0, 16));
      2: return 25'($urandom_range(0, 1200));
      3: return 25'($urandom_range(4090, 4100));
      4: return 25'(fb + 26'($urandom_range(0, 2)) - 26'd1);
      default: return 25'($urandom_range(0, 70000));
    endcase
  endfunction

  // mostly whole requests followed by their next steps, some cut short
  task automatic random_phase(input int unsigned target);
    int unsigned stop_at;
    int unsigned steps;
    logic [1:0]  cmd;
    logic [24:0] count;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 15) == 0) begin
        burst = ~burst;
      end
      cmd = ($urandom_range(0, 9) == 0) ? CMD_NEXT : 2'($urandom_range(0, 2));
      count = pick_count();
      offer(cmd, pick_address(), count);
      if (cmd == CMD_WRITE || cmd == CMD_ERASE) begin
        if ($urandom_range(0, 3) == 0) begin
          steps = $urandom_range(0, 3);
        end else begin
          steps = (count >> ((cmd == CMD_WRITE) ? 8 : 12)) + 2;
        end
        if (steps > 24) begin
          steps = 24;
        end
        repeat (steps) offer(CMD_NEXT, 24'($urandom), 25'($urandom));
      end
    end
  endtask

  initial begin : result_sink
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (200) @(posedge clk_i);
      end else begin
        gap = burst ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  initial begin : stimulus
    logic [16:0] sizes[5];
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset flash size of 4 MiB
    offer(CMD_READ, 24'h000000, 25'd0);
    offer(CMD_READ, 24'h000003, 25'd4096);
    offer(CMD_READ, 24'h000002, 25'd4097);
    offer(CMD_READ, 24'hFFFFFF, 25'h1FFFFFF);
    offer(CMD_READ, 24'h3FFFF9, 25'd40);
    offer(CMD_READ, 24'h400004, 25'd16);
    offer(CMD_NEXT, 24'h000000, 25'd0);
    offer(CMD_WRITE, 24'h000010, 25'd600);
    repeat (3) offer(CMD_NEXT, 24'h000000, 25'd0);
    offer(CMD_WRITE, 24'h000100, 25'd0);
    offer(CMD_WRITE, 24'h400000, 25'd5);
    offer(CMD_WRITE, 24'h3FFFF6, 25'd100);
    offer(CMD_NEXT, 24'h000000, 25'd0);
    offer(CMD_ERASE, 24'h000000, 25'h0400000);
    offer(CMD_ERASE, 24'h000000, 25'd0);
    offer(CMD_ERASE, 24'h000123, 25'd0);
    offer(CMD_ERASE, 24'h003000, 25'd69632);
    repeat (3) offer(CMD_NEXT, 24'h000000, 25'd0);
    offer(CMD_WRITE, 24'h000050, 25'd1000);
    offer(CMD_READ, 24'h000010, 25'd8);
    offer(CMD_NEXT, 24'h000000, 25'd0);
    offer(CMD_ERASE, 24'h3FF000, 25'd40000);
    repeat (2) offer(CMD_NEXT, 24'h000000, 25'd0);
    drain(4);

    // result side held off so the block fills and stalls its input
    hold_req = 1'b1;
    burst    = 1'b1;
    repeat (40) offer(CMD_READ, 24'($urandom), 25'($urandom_range(0, 64)));
    burst = 1'b0;
    drain(4);

    random_phase(100);
    drain(4);

    sizes[0] = 17'd1;
    sizes[1] = 17'd65536;
    sizes[2] = 17'($urandom_range(1, 65536));
    sizes[3] = 17'd2;
    sizes[4] = 17'($urandom_range(1, 512));
    foreach (sizes[i]) begin
      set_flash_pages(sizes[i]);
      random_phase(110);
      drain((i == 4) ? 10 : 4);
    end

    $display("covered %0d items over %0d flash sizes with random idling on both sides",
             items_sent, sizes_used);
    $display("compared %0d results, %0d mismatches", checked, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/frs_pkg.sv
src/frs_fifo.sv
src/frs_front.sv
src/frs_back.sv
src/flash_request_sequencer.sv
src/frs_checker.sv
tb/frs_plan_checker.sv
tb/tb_flash_request_sequencer.sv
